// File: rtl/tile_chunky_to_planar_top_assert.svh
`ifndef TILE_CHUNKY_TO_PLANAR_TOP_ASSERT_SVH
`define TILE_CHUNKY_TO_PLANAR_TOP_ASSERT_SVH

// same-cycle implication
`define TC2P_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TC2P_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tc2p_pkg.sv
package tc2p_pkg;

   localparam int TC2P_MAX_TILE_WIDTH  = 32;
   localparam int TC2P_MAX_TILE_HEIGHT = 16;

   localparam int STORE_DEPTH = 512;
   localparam int STORE_AW    = 9;
   localparam int COUNT_W     = 10;

   localparam logic [1:0] CSR_TILE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_TILE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BPP_LOG2    = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;      // write pixel into store, bump count (clear it on the tile's last pixel)
      logic rd_issue;  // read next pixel of current row
      logic emit;      // move row words to output register, advance row/pair
   } cmd_type;

   typedef struct packed {
      logic tile_complete;
      logic col_last;
      logic tile_last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/tc2p_ctrl.sv
module tc2p_ctrl
   import tc2p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

`include "tile_chunky_to_planar_top_assert.svh"

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.tile_complete) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (status.col_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.tile_last ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   `TC2P_ASSERT_NEXT(a_row_read_ends, clock, reset, (state_ff == ST_READ) && status.col_last, state_ff == ST_FLUSH, "row read did not end in flush")
   `TC2P_ASSERT_NEXT(a_tile_ends, clock, reset, cmd.emit && status.tile_last, state_ff == ST_LOAD, "last result did not return to load")
   `TC2P_ASSERT_NOW(a_no_accept_busy, clock, reset, cmd.rd_issue || cmd.emit, req_stall, "input taken while emitting")

endmodule

// File: rtl/tc2p_datapath.sv
module tc2p_datapath
   import tc2p_pkg::*;
#(
   parameter int MAX_TILE_WIDTH  = TC2P_MAX_TILE_WIDTH,
   parameter int MAX_TILE_HEIGHT = TC2P_MAX_TILE_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_plane_word_low,
   output logic [31:0] rsp_plane_word_high,
   output logic [1:0]  rsp_word_count,
   output logic [1:0]  rsp_plane_pair,
   output logic [3:0]  rsp_row,
   output logic        rsp_last,
   input  cmd_type     cmd,
   output status_type  status
);

`include "tile_chunky_to_planar_top_assert.svh"

   localparam int COL_W = $clog2(MAX_TILE_WIDTH);
   localparam logic [2:0] MAX_BYTES = 3'(MAX_TILE_WIDTH / 8);
   localparam logic [4:0] MAX_ROWS  = 5'(MAX_TILE_HEIGHT);

   logic [2:0] cfg_width_ff;
   logic [4:0] cfg_height_ff;
   logic [1:0] cfg_bpp_ff;

   logic [7:0] store_mem [STORE_DEPTH];
   logic [7:0] rdata_ff;
   logic       pend_ff;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [3:0]          row_ff, row_in;
   logic [1:0]          pair_ff, pair_in;
   logic [STORE_AW-1:0] base_ff, base_in;
   logic [MAX_TILE_WIDTH-1:0] word_lo_ff, word_lo_in;
   logic [MAX_TILE_WIDTH-1:0] word_hi_ff, word_hi_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [31:0] rsp_lo_ff, rsp_hi_ff;
   logic [1:0]  rsp_cnt_ff, rsp_pair_ff;
   logic [3:0]  rsp_row_ff;
   logic        rsp_last_ff;

   logic [2:0]          eff_bytes;
   logic [4:0]          eff_h;
   logic [5:0]          eff_w;
   logic [6:0]          bytes_rows;
   logic [COUNT_W-1:0]  total;
   logic [COUNT_W-1:0]  count_next;
   logic [1:0]          pair_max;
   logic                row_last;
   logic                pair_last;
   logic [STORE_AW-1:0] rd_addr;
   logic [2:0]          plane_lo;
   logic [2:0]          plane_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 3'd1;
         cfg_height_ff <= 5'd8;
         cfg_bpp_ff    <= 2'd2;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TILE_WIDTH:  cfg_width_ff  <= csr_data[2:0];
            CSR_TILE_HEIGHT: cfg_height_ff <= csr_data;
            CSR_BPP_LOG2:    cfg_bpp_ff    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_bytes = cfg_width_ff;
      if (eff_bytes == 3'd0) eff_bytes = 3'd1;
      if (eff_bytes > MAX_BYTES) eff_bytes = MAX_BYTES;
      eff_h = cfg_height_ff;
      if (eff_h == 5'd0) eff_h = 5'd1;
      if (eff_h > MAX_ROWS) eff_h = MAX_ROWS;
   end

   assign eff_w      = {eff_bytes, 3'b000};
   assign bytes_rows = 7'(eff_bytes) * 7'(eff_h);
   assign total      = {bytes_rows, 3'b000};
   assign count_next = count_ff + COUNT_W'(1);
   assign pair_max   = cfg_bpp_ff[1] ? (cfg_bpp_ff[0] ? 2'd3 : 2'd1) : 2'd0;
   assign row_last   = {1'b0, row_ff} == (eff_h - 5'd1);
   assign pair_last  = pair_ff == pair_max;
   assign rd_addr    = base_ff + STORE_AW'(col_ff);
   assign plane_lo   = {pair_ff, 1'b0};
   assign plane_hi   = {pair_ff, 1'b1};

   assign status.tile_complete = count_next >= total;
   assign status.col_last      = 6'(col_ff) == (eff_w - 6'd1);
   assign status.tile_last     = row_last && pair_last;
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   // tile store
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_mem[count_ff[STORE_AW-1:0]] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pair_in      = pair_ff;
      base_in      = base_ff;
      word_lo_in   = word_lo_ff;
      word_hi_in   = word_hi_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (pend_ff) begin
         word_lo_in = {word_lo_ff[MAX_TILE_WIDTH-2:0], rdata_ff[plane_lo]};
         word_hi_in = {word_hi_ff[MAX_TILE_WIDTH-2:0], rdata_ff[plane_hi]};
      end

      if (cmd.rd_issue) col_in = col_ff + COL_W'(1);

      if (cmd.load) begin
         col_in     = '0;
         word_lo_in = '0;
         word_hi_in = '0;
         if (status.tile_complete) begin
            count_in = '0;
            row_in   = '0;
            pair_in  = '0;
            base_in  = '0;
         end else begin
            count_in = count_next;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         col_in       = '0;
         word_lo_in   = '0;
         word_hi_in   = '0;
         if (row_last) begin
            row_in  = '0;
            base_in = '0;
            pair_in = pair_last ? 2'd0 : pair_ff + 2'd1;
         end else begin
            row_in  = row_ff + 4'd1;
            base_in = base_ff + STORE_AW'(eff_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pair_ff      <= '0;
         base_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pair_ff      <= pair_in;
         base_ff      <= base_in;
         pend_ff      <= cmd.rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_lo_ff <= word_lo_in;
      word_hi_ff <= word_hi_in;
      if (cmd.emit) begin
         rsp_lo_ff   <= 32'(word_lo_ff);
         rsp_hi_ff   <= (cfg_bpp_ff == 2'd0) ? 32'd0 : 32'(word_hi_ff);
         rsp_cnt_ff  <= (cfg_bpp_ff == 2'd0) ? 2'd1 : 2'd2;
         rsp_pair_ff <= pair_ff;
         rsp_row_ff  <= row_ff;
         rsp_last_ff <= status.tile_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_plane_word_low  = rsp_lo_ff;
   assign rsp_plane_word_high = rsp_hi_ff;
   assign rsp_word_count      = rsp_cnt_ff;
   assign rsp_plane_pair      = rsp_pair_ff;
   assign rsp_row             = rsp_row_ff;
   assign rsp_last            = rsp_last_ff;

   `TC2P_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || !rsp_stall, "result overwritten before taken")
   `TC2P_ASSERT_NOW(a_no_rd_on_load, clock, reset, cmd.rd_issue, !cmd.load && !cmd.emit, "store read during load or emit")
   `TC2P_ASSERT_NEXT(a_tile_reset, clock, reset, cmd.load && status.tile_complete, (count_ff == '0) && (row_ff == '0) && (pair_ff == '0) && (base_ff == '0), "pointers not cleared at tile end")

endmodule

// File: rtl/tile_chunky_to_planar_top.sv
// Chunky-to-planar tile converter. Pixels of one tile (tile_width_bytes*8 by
// tile_height) are taken one per cycle in row-major order into a 512-byte
// tile store. The transaction carrying the final pixel starts emission and
// input stalls until the last result of the tile enters the output register.
// Emission produces max(planes/2,1)*height results, plane pair outer, row
// inner; each result is built as the single store read port delivers one
// pixel per cycle and each pixel feeds both plane words of the pair.
// Emission waits while the result side stalls. Configuration is to be
// written by the user only between tiles or with no result pending; the
// block itself does not enforce it.
module tile_chunky_to_planar_top
   import tc2p_pkg::*;
#(
   parameter int MAX_TILE_WIDTH  = TC2P_MAX_TILE_WIDTH,
   parameter int MAX_TILE_HEIGHT = TC2P_MAX_TILE_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_plane_word_low,
   output logic [31:0] rsp_plane_word_high,
   output logic [1:0]  rsp_word_count,
   output logic [1:0]  rsp_plane_pair,
   output logic [3:0]  rsp_row,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type status;

   tc2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tc2p_datapath #(
      .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
      .MAX_TILE_HEIGHT (MAX_TILE_HEIGHT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_plane_word_low  (rsp_plane_word_low),
      .rsp_plane_word_high (rsp_plane_word_high),
      .rsp_word_count      (rsp_word_count),
      .rsp_plane_pair      (rsp_plane_pair),
      .rsp_row             (rsp_row),
      .rsp_last            (rsp_last),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// File: dv/tile_chunky_to_planar_top_tb.sv
module tile_chunky_to_planar_top_tb;
   import tc2p_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS   = 220;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_PIXELS = 128;

   typedef struct packed {
      logic [31:0] word_low;
      logic [31:0] word_high;
      logic [1:0]  word_count;
      logic [1:0]  plane_pair;
      logic [3:0]  row;
      logic        last;
   } plane_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_TILE_WIDTH;
   logic [4:0]  csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_plane_word_low;
   logic [31:0] rsp_plane_word_high;
   logic [1:0]  rsp_word_count;
   logic [1:0]  rsp_plane_pair;
   logic [3:0]  rsp_row;
   logic        rsp_last;

   tile_chunky_to_planar_top DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_plane_word_low  (rsp_plane_word_low),
      .rsp_plane_word_high (rsp_plane_word_high),
      .rsp_word_count      (rsp_word_count),
      .rsp_plane_pair      (rsp_plane_pair),
      .rsp_row             (rsp_row),
      .rsp_last            (rsp_last)
   );

   always #10 clock = ~clock;

   // shadow of the converter
   logic [7:0]  tile_mem [STORE_DEPTH];
   int unsigned pixels_held = 0;
   logic [2:0]  cfg_width = 3'd1;
   logic [4:0]  cfg_height = 5'd8;
   logic [1:0]  cfg_bpp_log2 = 2'd2;

   logic [7:0]    pixel_backlog [$];
   plane_row_type expected_rows [$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   logic        req_taken = 1'b0;
   bit          idle_enable = 1'b1;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          flow_left = 0;
   int          send_gap = 0;

   function automatic int unsigned tile_cols();
      int unsigned b;
      b = cfg_width;
      if (b == 0) b = 1;
      if (b > TC2P_MAX_TILE_WIDTH / 8) b = TC2P_MAX_TILE_WIDTH / 8;
      return b * 8;
   endfunction

   function automatic int unsigned tile_rows();
      int unsigned h;
      h = cfg_height;
      if (h == 0) h = 1;
      if (h > TC2P_MAX_TILE_HEIGHT) h = TC2P_MAX_TILE_HEIGHT;
      return h;
   endfunction

   function automatic logic [31:0] plane_row_bits(int unsigned cols, int unsigned r,
                                                  int unsigned plane);
      logic [31:0] bits;
      bits = '0;
      for (int unsigned j = 0; j < cols; j++)
         if (tile_mem[(r * cols + j) % STORE_DEPTH][plane % 8])
            bits[cols - 1 - j] = 1'b1;
      return bits;
   endfunction

   function automatic void absorb_pixel(logic [7:0] px);
      int unsigned   cols, rows, planes;
      plane_row_type rec;
      cols = tile_cols();
      rows = tile_rows();
      planes = 1 << cfg_bpp_log2;
      tile_mem[pixels_held % STORE_DEPTH] = px;
      pixels_held = (pixels_held + 1) % (1 << COUNT_W);
      if (pixels_held < cols * rows) return;
      pixels_held = 0;
      for (int unsigned m = 0; m < planes; m += 2) begin
         for (int unsigned r = 0; r < rows; r++) begin
            rec.word_low   = plane_row_bits(cols, r, m);
            rec.word_high  = (planes >= 2) ? plane_row_bits(cols, r, m + 1) : '0;
            rec.word_count = (planes >= 2) ? 2'd2 : 2'd1;
            rec.plane_pair = 2'(m / 2);
            rec.row        = 4'(r);
            rec.last       = (m + 2 >= planes) && (r + 1 == rows);
            expected_rows.push_back(rec);
         end
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idle_enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // predictor and checker
   always @(posedge clock) begin
      plane_row_type got, want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) absorb_pixel(req_pixel);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_plane_word_low, rsp_plane_word_high, rsp_word_count,
                    rsp_plane_pair, rsp_row, rsp_last};
            if (expected_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: low=%h high=%h count=%0d pair=%0d row=%0d last=%0b",
                           got.word_low, got.word_high, got.word_count, got.plane_pair,
                           got.row, got.last);
            end else begin
               want = expected_rows.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("mismatch: exp low=%h high=%h count=%0d pair=%0d row=%0d last=%0b",
                              want.word_low, want.word_high, want.word_count,
                              want.plane_pair, want.row, want.last);
                     $display("          got low=%h high=%h count=%0d pair=%0d row=%0d last=%0b",
                              got.word_low, got.word_high, got.word_count,
                              got.plane_pair, got.row, got.last);
                  end
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tile_chunky_to_planar_top_tb NOT OK");
         $finish;
      end
   end

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pixel_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_backlog.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left <= flow_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
         flow_left <= $urandom_range(0, 12);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [4:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TILE_WIDTH:  cfg_width = value[2:0];
         CSR_TILE_HEIGHT: cfg_height = value;
         CSR_BPP_LOG2:    cfg_bpp_log2 = value[1:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(logic [4:0] w, logic [4:0] h, logic [4:0] bpp);
      write_reg(CSR_TILE_WIDTH, w);
      write_reg(CSR_TILE_HEIGHT, h);
      write_reg(CSR_BPP_LOG2, bpp);
   endtask

   task automatic queue_pixels(int unsigned n);
      repeat (n) pixel_backlog.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_valid || expected_rows.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned sent, tiles, n, total;
      logic [4:0] w, h;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // one tile at the reset shape: 8x8, four planes
      queue_pixels(64);
      sent = 64;
      wait_drained();

      // 8x1, eight planes, edge pixel values
      set_shape(5'd1, 5'd1, 5'd3);
      pixel_backlog = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h0F, 8'hF0};
      sent += 8;
      wait_drained();

      // zero width and height act as one; single plane
      set_shape(5'd0, 5'd0, 5'd0);
      pixel_backlog = '{8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hC3, 8'h3C};
      sent += 8;
      wait_drained();

      // shrink the tile mid-load: next pixel completes it
      set_shape(5'd1, 5'd2, 5'd1);
      queue_pixels(10);
      wait_drained();
      write_reg(CSR_TILE_HEIGHT, 5'd1);
      write_reg(CSR_UNUSED, 5'h1F);
      queue_pixels(1);
      sent += 11;
      wait_drained();

      // width above range clamps to 32
      set_shape(5'd7, 5'd1, 5'd2);
      queue_pixels(32);
      sent += 32;
      wait_drained();

      // receiver holds off while further tiles wait at the input
      set_shape(5'd1, 5'd1, 5'd3);
      holds_asked++;
      queue_pixels(24);
      sent += 24;
      wait_drained();

      while (sent < TOTAL_ITEMS) begin
         w = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 2));
         h = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
         if ($urandom_range(0, 2) != 0) write_reg(CSR_TILE_WIDTH, w);
         if ($urandom_range(0, 2) != 0) write_reg(CSR_TILE_HEIGHT, h);
         if ($urandom_range(0, 2) != 0) write_reg(CSR_BPP_LOG2, 5'($urandom_range(0, 31)));
         if ($urandom_range(0, 5) == 0) write_reg(CSR_UNUSED, 5'($urandom_range(0, 31)));
         if (tile_cols() * tile_rows() > RANDOM_PIXELS)
            write_reg(CSR_TILE_HEIGHT, 5'(RANDOM_PIXELS / tile_cols()));
         idle_enable = ($urandom_range(0, 3) != 0);
         total = tile_cols() * tile_rows();
         tiles = (total > 32) ? 1 : $urandom_range(1, 2);
         n = tiles * total;
         if (total <= 32 && $urandom_range(0, 4) == 0) n += $urandom_range(1, total - 1);
         queue_pixels(n);
         sent += n;
         wait_drained();
      end

      idle_enable = 1'b1;
      wait_drained();
      if (mismatches == 0 && expected_rows.size() == 0)
         $display("tile_chunky_to_planar_top_tb OK");
      else
         $display("tile_chunky_to_planar_top_tb NOT OK");
      $finish;
   end

endmodule
